### hw/rtl/rarp_pkg.sv
// Shared types and constants for the rack-aware replica picker.
// Used by every module under hw/rtl; depends on nothing else.
`timescale 1ns / 1ps

package rarp_pkg;

    localparam int ZONES  = 4;
    localparam int RACKS  = 16;
    localparam int NODES  = 256;

    localparam int EP_W   = 8;
    localparam int ZONE_W = 2;
    localparam int RACK_W = 4;
    localparam int SLOT_W = ZONE_W + RACK_W;
    localparam int SLOTS  = ZONES * RACKS;
    localparam int CNT_W  = 8;
    localparam int REP_W  = 9;
    localparam int ZCNT_W = 3;
    localparam int BYTE_W = 8;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_USED_W  = 1 + CNT_W + 1 + 1;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RF    = 2'd0,
        CFG_RACKS = 2'd1,
        CFG_NODES = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_OFFER = 1'b1
    } func_t;

    typedef struct packed {
        func_t             func;
        logic [EP_W-1:0]   endpoint;
        logic [ZONE_W-1:0] zone;
        logic [RACK_W-1:0] rack;
    } item_t;

    typedef struct packed {
        logic             accepted;
        logic [CNT_W-1:0] position;
        logic             all_done;
        logic             status;
    } result_t;

endpackage

### hw/rtl/rarp_in_stage.sv
// Input register of the replica picker: holds one offered transaction.
// Depends on rarp_pkg.
`timescale 1ns / 1ps

module rarp_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  rarp_pkg::item_t s_item,
    output logic            q_valid,
    input  logic            q_ready,
    output rarp_pkg::item_t q_item
);
    import rarp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The held item leaves whenever the core can pass it on.
    assign s_ready = !valid_reg || q_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (q_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign q_valid = valid_reg;
    assign q_item  = item_reg;

endmodule

### hw/rtl/rarp_core.sv
// Search state and per-item decision logic of the replica picker.
// Holds the configuration tables; depends on rarp_pkg.
`timescale 1ns / 1ps

module rarp_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [rarp_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [rarp_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    input  rarp_pkg::item_t               in_item,
    input  logic                          out_ready,
    output logic                          res_valid,
    output rarp_pkg::result_t             res
);
    import rarp_pkg::*;

    logic [CFG_W-1:0] rf_table_reg;
    logic [CFG_W-1:0] rack_table_reg;
    logic [CFG_W-1:0] node_table_reg;

    logic [SLOTS-1:0]                seen_reg,    seen_next;
    logic [NODES-1:0]                chosen_reg,  chosen_next;
    logic [ZONES-1:0][CNT_W-1:0]     left_reg,    left_next;
    logic [ZONES-1:0][REP_W-1:0]     rep_reg,     rep_next;
    logic [ZONES-1:0]                tracked_reg, tracked_next;
    logic [ZCNT_W-1:0]               ztf_reg,     ztf_next;
    logic [CNT_W-1:0]                count_reg,   count_next;

    logic fire;
    assign fire      = in_valid && out_ready;
    assign res_valid = fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_table_reg   <= '0;
            rack_table_reg <= '0;
            node_table_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_RF:    rf_table_reg   <= cfg_wdata;
                CFG_RACKS: rack_table_reg <= cfg_wdata;
                CFG_NODES: node_table_reg <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    always_comb begin
        logic [BYTE_W-1:0] rf_b;
        logic [BYTE_W-1:0] rk_b;
        logic [BYTE_W-1:0] nd_b;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  cur_left;
        logic [REP_W-1:0]  cur_rep;
        logic              take;

        seen_next    = seen_reg;
        chosen_next  = chosen_reg;
        left_next    = left_reg;
        rep_next     = rep_reg;
        tracked_next = tracked_reg;
        ztf_next     = ztf_reg;
        count_next   = count_reg;
        res          = '0;
        take         = 1'b0;
        slot         = {in_item.zone, in_item.rack};
        cur_left     = left_reg[in_item.zone];
        cur_rep      = rep_reg[in_item.zone];
        rf_b         = '0;
        rk_b         = '0;
        nd_b         = '0;

        if (fire) begin
            if (in_item.func == FUNC_START) begin
                seen_next   = '0;
                chosen_next = '0;
                count_next  = '0;
                ztf_next    = '0;
                for (int z = 0; z < ZONES; z++) begin
                    rf_b = rf_table_reg[BYTE_W*z +: BYTE_W];
                    rk_b = rack_table_reg[BYTE_W*z +: BYTE_W];
                    nd_b = node_table_reg[BYTE_W*z +: BYTE_W];
                    tracked_next[z] = (rf_b != '0) && (nd_b != '0);
                    if (tracked_next[z]) begin
                        left_next[z] = (rf_b < nd_b) ? rf_b : nd_b;
                        rep_next[z]  = {1'b0, rf_b} - {1'b0, rk_b};
                        ztf_next     = ztf_next + ZCNT_W'(1);
                    end else begin
                        left_next[z] = '0;
                        rep_next[z]  = '0;
                    end
                end
            end else if (tracked_reg[in_item.zone] && (cur_left != '0)) begin
                // Every field value is in range at these widths.
                if (!seen_reg[slot]) begin
                    if (chosen_reg[in_item.endpoint]) begin
                        res.status = 1'b1;
                    end else begin
                        seen_next[slot] = 1'b1;
                        take            = 1'b1;
                    end
                end else if ($signed(cur_rep) > $signed(REP_W'(0)) &&
                             !chosen_reg[in_item.endpoint]) begin
                    rep_next[in_item.zone] = cur_rep - REP_W'(1);
                    take                   = 1'b1;
                end
                if (take) begin
                    chosen_next[in_item.endpoint] = 1'b1;
                    left_next[in_item.zone]       = cur_left - CNT_W'(1);
                    res.accepted                  = 1'b1;
                    res.position                  = count_reg;
                    count_next                    = count_reg + CNT_W'(1);
                    if (cur_left == CNT_W'(1) && ztf_reg != '0) begin
                        ztf_next = ztf_reg - ZCNT_W'(1);
                    end
                end
            end
            res.all_done = (ztf_next == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            chosen_reg  <= '0;
            left_reg    <= '0;
            rep_reg     <= '0;
            tracked_reg <= '0;
            ztf_reg     <= '0;
            count_reg   <= '0;
        end else begin
            seen_reg    <= seen_next;
            chosen_reg  <= chosen_next;
            left_reg    <= left_next;
            rep_reg     <= rep_next;
            tracked_reg <= tracked_next;
            ztf_reg     <= ztf_next;
            count_reg   <= count_next;
        end
    end

`ifndef SYNTHESIS
    logic [ZONES-1:0] zone_open;
    always_comb begin
        for (int z = 0; z < ZONES; z++) begin
            zone_open[z] = tracked_reg[z] && (left_reg[z] != '0);
        end
    end

    // The fill count always equals the number of tracked zones still open.
    a_ztf_matches_open: assert property (@(posedge aclk) disable iff (!aresetn)
        ztf_reg == ZCNT_W'($countones(zone_open)))
        else $error("zones_to_fill disagrees with open zones");

    // A start empties both bitmaps and the replica count.
    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_item.func == FUNC_START |=>
            count_reg == '0 && chosen_reg == '0 && seen_reg == '0)
        else $error("start did not clear the search state");

    // An accepted offer marks its endpoint as chosen.
    a_accept_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.accepted |=> chosen_reg[$past(in_item.endpoint)])
        else $error("accepted endpoint not marked");

    // Offers never change which zones take part in the search.
    a_offer_keeps_tracked: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_item.func == FUNC_OFFER |=> $stable(tracked_reg))
        else $error("offer changed the tracked zones");
`endif

endmodule

### hw/rtl/rarp_out_stage.sv
// Result register of the replica picker: holds one result until taken.
// Depends on rarp_pkg.
`timescale 1ns / 1ps

module rarp_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              d_valid,
    output logic              d_ready,
    input  rarp_pkg::result_t d_res,
    output logic              m_valid,
    input  logic              m_ready,
    output rarp_pkg::result_t m_res
);
    import rarp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // A new result may replace the held one in the cycle it is taken.
    assign d_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (d_valid && d_ready) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (d_valid && d_ready) begin
            res_reg <= d_res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

### hw/rtl/rack_aware_replica_picker.sv
// Top level of the rack-aware replica picker.
// Instantiates rarp_in_stage, rarp_core and rarp_out_stage; uses rarp_pkg.
`timescale 1ns / 1ps

// The picker takes one transaction per clock cycle while neither side stalls.
// An accepted input transaction passes through the input register and then
// the result register on its way to the master side. The single update stage
// between them lets each item read and write the rack and endpoint bitmaps and
// the per-zone counters combinationally, registering the update, so the
// next item always sees the state its predecessor left. A start transaction
// (tuser low) arms a new search from the three configuration tables and
// clears both bitmaps; an offer transaction (tuser high) presents one
// endpoint with its zone and rack. Every input transaction yields exactly one
// result. Configuration writes must only be issued while no transaction is in
// flight. Both sides may stall freely; while a result waits to be taken, the
// input register can still take one more item, and the update stage holds
// until the result register frees up.

module rack_aware_replica_picker (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [rarp_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [rarp_pkg::CFG_W-1:0]          cfg_wdata,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // endpoint [7:0], zone [9:8], rack [13:10], zero [15:14]
    input  logic [rarp_pkg::IN_TDATA_W-1:0]     s_tdata,
    // func [0]: 0 start a search, 1 offer an endpoint
    input  logic                                s_tuser,
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // accepted [0], position [8:1], all_done [9], status [10], zero [15:11]
    output logic [rarp_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import rarp_pkg::*;

    item_t   s_item;
    item_t   q_item;
    logic    q_valid;
    logic    core_ready;
    logic    res_valid;
    result_t core_res;
    result_t m_res;

    assign s_item.func     = func_t'(s_tuser);
    assign s_item.endpoint = s_tdata[EP_W-1:0];
    assign s_item.zone     = s_tdata[EP_W+ZONE_W-1:EP_W];
    assign s_item.rack     = s_tdata[EP_W+ZONE_W+RACK_W-1:EP_W+ZONE_W];

    rarp_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_ready (core_ready),
        .q_item  (q_item)
    );

    rarp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (q_valid),
        .in_item   (q_item),
        .out_ready (core_ready),
        .res_valid (res_valid),
        .res       (core_res)
    );

    rarp_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .d_valid (res_valid),
        .d_ready (core_ready),
        .d_res   (core_res),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (m_res)
    );

    assign m_tdata = {{OUT_PAD_W{1'b0}}, m_res.status, m_res.all_done,
                      m_res.position, m_res.accepted};

endmodule

### tb/sv/rack_aware_replica_picker_tb.sv
// Self-checking testbench for rack_aware_replica_picker: drives start and offer
// transactions, predicts every result in its own replica model and compares.
// Depends on rarp_pkg and the picker RTL only.
`timescale 1ns / 1ps

module rack_aware_replica_picker_tb;

    import rarp_pkg::*;

    // Idling patterns of the two stream sides, one per phase of the run.
    typedef enum int {
        PACE_NONE,
        PACE_SEND,
        PACE_RECV,
        PACE_BOTH
    } pace_t;

    localparam int ITEMS_PER_PHASE = 150;
    localparam int RANDOM_PHASES   = 8;
    localparam int SETTLE_CYCLES   = 8;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_addr  = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // endpoint [7:0], zone [9:8], rack [13:10], zero [15:14]
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    // func [0]: 0 start a search, 1 offer an endpoint
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // accepted [0], position [8:1], all_done [9], status [10], zero [15:11]
    logic [OUT_TDATA_W-1:0] m_tdata;

    rack_aware_replica_picker i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Items waiting to be driven, and the results predicted for accepted ones.
    item_t   pending_items[$];
    result_t expected_picks[$];

    int items_queued   = 0;
    int items_taken    = 0;
    int results_seen   = 0;
    int picks_accepted = 0;
    int rack_conflicts = 0;
    int settings_used  = 0;
    int error_count    = 0;
    int send_hold_pct  = 0;
    int recv_stall_pct = 0;

    // The testbench's own copy of the configuration tables and search state.
    logic [CFG_W-1:0]         cfg_rf     = '0;
    logic [CFG_W-1:0]         cfg_racks  = '0;
    logic [CFG_W-1:0]         cfg_nodes  = '0;
    logic [SLOTS-1:0]         seen_rack  = '0;
    logic [NODES-1:0]         chosen_ep  = '0;
    logic [CNT_W-1:0]         left_cnt [ZONES];
    logic signed [REP_W-1:0]  rep_cnt  [ZONES];
    logic [ZONES-1:0]         tracked    = '0;
    logic [ZCNT_W-1:0]        to_fill    = '0;
    logic [CNT_W-1:0]         replica_cnt = '0;

    initial begin
        for (int z = 0; z < ZONES; z++) begin
            left_cnt[z] = '0;
            rep_cnt[z]  = '0;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // A start arms every zone whose replication factor and node count are both
    // nonzero; the zone must place min(rf, nodes) replicas and may reuse a rack
    // rf - racks times, which is negative when the zone has racks to spare.
    function automatic void arm_search();
        logic [BYTE_W-1:0] rf, rk, nd;
        seen_rack   = '0;
        chosen_ep   = '0;
        tracked     = '0;
        to_fill     = '0;
        replica_cnt = '0;
        for (int z = 0; z < ZONES; z++) begin
            rf = cfg_rf[BYTE_W*z +: BYTE_W];
            rk = cfg_racks[BYTE_W*z +: BYTE_W];
            nd = cfg_nodes[BYTE_W*z +: BYTE_W];
            left_cnt[z] = '0;
            rep_cnt[z]  = '0;
            if (rf != 0 && nd != 0) begin
                left_cnt[z] = (rf < nd) ? rf : nd;
                rep_cnt[z]  = $signed({1'b0, rf}) - $signed({1'b0, rk});
                tracked[z]  = 1'b1;
                to_fill     = to_fill + ZCNT_W'(1);
            end
        end
    endfunction

    // Works out the result of one accepted transaction and advances the state.
    function automatic result_t predict_pick(input item_t it);
        result_t r;
        int      slot;
        logic    take;
        r    = '0;
        take = 1'b0;
        slot = it.zone * RACKS + it.rack;
        if (it.func == FUNC_START) begin
            arm_search();
        end else if (tracked[it.zone] && left_cnt[it.zone] != 0) begin
            if (!seen_rack[slot]) begin
                // A fresh rack offered by an endpoint that is already a replica
                // is an error and leaves the rack unmarked.
                if (chosen_ep[it.endpoint]) begin
                    r.status = 1'b1;
                end else begin
                    seen_rack[slot] = 1'b1;
                    take = 1'b1;
                end
            end else if (rep_cnt[it.zone] > 0 && !chosen_ep[it.endpoint]) begin
                rep_cnt[it.zone] = rep_cnt[it.zone] - REP_W'(1);
                take = 1'b1;
            end
            if (take) begin
                chosen_ep[it.endpoint] = 1'b1;
                left_cnt[it.zone]      = left_cnt[it.zone] - CNT_W'(1);
                r.accepted             = 1'b1;
                r.position             = replica_cnt;
                replica_cnt            = replica_cnt + CNT_W'(1);
                if (left_cnt[it.zone] == 0 && to_fill != 0)
                    to_fill = to_fill - ZCNT_W'(1);
            end
        end
        r.all_done = (to_fill == 0);
        return r;
    endfunction

    task automatic queue_item(input func_t f, input logic [EP_W-1:0] ep,
                              input logic [ZONE_W-1:0] zn, input logic [RACK_W-1:0] rk);
        item_t it;
        it.func     = f;
        it.endpoint = ep;
        it.zone     = zn;
        it.rack     = rk;
        pending_items.insert(pending_items.size(), it);
        items_queued++;
    endtask

    task automatic set_pace(input pace_t p);
        send_hold_pct  = (p == PACE_SEND) ? 88 : (p == PACE_BOTH) ? 32 : 0;
        recv_stall_pct = (p == PACE_RECV) ? 88 : (p == PACE_BOTH) ? 32 : 0;
    endtask

    // Blocks until every queued transaction was taken and every result has
    // arrived, then lets the two pipeline stages drain with some margin.
    task automatic wait_idle();
        while (items_taken != items_queued || expected_picks.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register writes are only issued while the picker is idle, so the model
    // copy can be updated at once.
    task automatic write_tables(input logic [CFG_W-1:0] rf, input logic [CFG_W-1:0] racks,
                                input logic [CFG_W-1:0] nodes);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_RF;
        cfg_wdata <= rf;
        @(posedge aclk);
        cfg_addr  <= CFG_RACKS;
        cfg_wdata <= racks;
        @(posedge aclk);
        cfg_addr  <= CFG_NODES;
        cfg_wdata <= nodes;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cfg_rf    = rf;
        cfg_racks = racks;
        cfg_nodes = nodes;
        settings_used++;
    endtask

    // Mostly small per-zone values so that searches complete, with the odd
    // zero and all-ones byte mixed in.
    function automatic logic [CFG_W-1:0] pick_table(input int hi);
        logic [CFG_W-1:0] v;
        int               r;
        for (int z = 0; z < ZONES; z++) begin
            r = $urandom_range(99);
            if (r < 10)
                v[BYTE_W*z +: BYTE_W] = '0;
            else if (r < 18)
                v[BYTE_W*z +: BYTE_W] = '1;
            else
                v[BYTE_W*z +: BYTE_W] = BYTE_W'($urandom_range(hi));
        end
        return v;
    endfunction

    // Driver: presents the next pending item once the current transaction has
    // completed, and paces both sides according to the phase.
    always @(posedge aclk) begin
        item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_hold_pct) begin
                    nxt = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.func;
                    s_tdata  <= {2'b00, nxt.rack, nxt.zone, nxt.endpoint};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: predicts each accepted input transaction and checks each result
    // transaction against the oldest prediction.
    always @(posedge aclk) begin
        item_t   it;
        result_t got;
        result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                it.func     = func_t'(s_tuser);
                it.endpoint = s_tdata[7:0];
                it.zone     = s_tdata[9:8];
                it.rack     = s_tdata[13:10];
                expected_picks.insert(expected_picks.size(), predict_pick(it));
                items_taken++;
            end
            if (m_tvalid && m_tready) begin
                got.accepted = m_tdata[0];
                got.position = m_tdata[8:1];
                got.all_done = m_tdata[9];
                got.status   = m_tdata[10];
                results_seen++;
                if (expected_picks.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                end else begin
                    want = expected_picks.pop_front();
                    picks_accepted += want.accepted;
                    rack_conflicts += want.status;
                    if (got.accepted !== want.accepted)
                        report_mismatch($sformatf("result %0d: accepted %0b, expected %0b",
                                                  results_seen, got.accepted, want.accepted));
                    if (got.position !== want.position)
                        report_mismatch($sformatf("result %0d: position %0d, expected %0d",
                                                  results_seen, got.position, want.position));
                    if (got.all_done !== want.all_done)
                        report_mismatch($sformatf("result %0d: all_done %0b, expected %0b",
                                                  results_seen, got.all_done, want.all_done));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("result %0d: status %0b, expected %0b",
                                                  results_seen, got.status, want.status));
                end
            end
        end
    end

    initial begin
        int               budget, n, spread, rack_hi, j;
        logic [EP_W-1:0]  base, tmp;
        logic [EP_W-1:0]  order [NODES];

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        set_pace(PACE_NONE);

        // Straight out of reset no zone is tracked: everything is done at once
        // and offers are turned away, before and after a start.
        queue_item(FUNC_OFFER, 8'd255, 2'd3, 4'd15);
        queue_item(FUNC_START, 8'd0, 2'd0, 4'd0);
        queue_item(FUNC_OFFER, 8'd0, 2'd0, 4'd0);
        wait_idle();

        // Zone 0: rf 3, 2 racks, so one rack repeat. Zone 1: rf 2 with 4 racks,
        // no repeats. Zone 2: rf 5 but only 2 nodes, so two replicas suffice.
        // Zone 3 has rf 0 and is not tracked.
        write_tables(32'h00_05_02_03, 32'h07_01_04_02, 32'h09_02_FF_0A);
        queue_item(FUNC_START, 8'd0, 2'd0, 4'd0);
        queue_item(FUNC_OFFER, 8'd10, 2'd0, 4'd0);    // new rack
        queue_item(FUNC_OFFER, 8'd11, 2'd0, 4'd0);    // the one allowed repeat
        queue_item(FUNC_OFFER, 8'd12, 2'd0, 4'd0);    // repeats used up
        queue_item(FUNC_OFFER, 8'd10, 2'd0, 4'd5);    // chosen endpoint, new rack
        queue_item(FUNC_OFFER, 8'd13, 2'd0, 4'd5);    // completes zone 0
        queue_item(FUNC_OFFER, 8'd14, 2'd0, 4'd6);    // zone already complete
        queue_item(FUNC_OFFER, 8'd0, 2'd3, 4'd0);     // untracked zone
        queue_item(FUNC_OFFER, 8'd255, 2'd1, 4'd15);
        queue_item(FUNC_OFFER, 8'd20, 2'd1, 4'd15);   // repeat with negative allowance
        queue_item(FUNC_OFFER, 8'd21, 2'd1, 4'd3);    // completes zone 1
        queue_item(FUNC_OFFER, 8'd30, 2'd2, 4'd0);
        queue_item(FUNC_OFFER, 8'd31, 2'd2, 4'd0);    // repeat finishes all zones
        queue_item(FUNC_OFFER, 8'd40, 2'd2, 4'd1);    // offer after all are done
        queue_item(FUNC_START, 8'd0, 2'd0, 4'd0);
        queue_item(FUNC_OFFER, 8'd10, 2'd0, 4'd0);    // bitmaps were cleared
        wait_idle();

        // Largest tables with no racks: every endpoint can be taken once, so a
        // shuffled sweep of all of them runs the replica count through a wrap.
        write_tables('1, '0, '1);
        for (int i = 0; i < NODES; i++)
            order[i] = EP_W'(i);
        for (int i = NODES - 1; i > 0; i--) begin
            j        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        queue_item(FUNC_START, 8'd0, 2'd0, 4'd0);
        for (int i = 0; i < NODES; i++)
            queue_item(FUNC_OFFER, order[i], ZONE_W'($urandom_range(3)),
                       RACK_W'($urandom_range(15)));
        for (int i = 0; i < 8; i++)
            queue_item(FUNC_OFFER, EP_W'($urandom), ZONE_W'($urandom_range(3)),
                       RACK_W'($urandom_range(15)));
        wait_idle();

        // Random phases: each gets its own tables and idling pattern. Most of
        // the stimulus is searches that walk a small pool of endpoints over a
        // few racks, so that repeats, conflicts and completion all occur; the
        // rest is unconstrained noise.
        for (int ph = 0; ph < RANDOM_PHASES + 1; ph++) begin
            set_pace(pace_t'(ph % 4));
            if (ph == 0)
                write_tables('1, '1, '1);
            else
                write_tables(pick_table(6), pick_table(6), pick_table(8));
            budget = items_queued + ITEMS_PER_PHASE;
            while (items_queued < budget) begin
                if ($urandom_range(99) < 85) begin
                    n       = $urandom_range(30, 4);
                    base    = EP_W'($urandom);
                    spread  = $urandom_range(40, 3);
                    rack_hi = ($urandom_range(2) == 0) ? 15 : $urandom_range(3, 1);
                    queue_item(FUNC_START, EP_W'($urandom), ZONE_W'($urandom_range(3)),
                               RACK_W'($urandom_range(15)));
                    for (int k = 0; k < n; k++)
                        queue_item(FUNC_OFFER, EP_W'(base + $urandom_range(spread)),
                                   ZONE_W'($urandom_range(3)),
                                   RACK_W'($urandom_range(rack_hi)));
                end else begin
                    n = $urandom_range(5, 1);
                    for (int k = 0; k < n; k++)
                        queue_item(func_t'($urandom_range(1)), EP_W'($urandom),
                                   ZONE_W'($urandom_range(3)), RACK_W'($urandom_range(15)));
                end
            end
            wait_idle();
        end

        $display("Ran %0d transactions under %0d table settings and four idling patterns.",
                 items_taken, settings_used);
        $display("Results checked: %0d, replicas placed: %0d, rack conflicts flagged: %0d.",
                 results_seen, picks_accepted, rack_conflicts);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("Timeout: %0d of %0d transactions taken, %0d results outstanding.",
                 items_taken, items_queued, expected_picks.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
